// ----- hdl/masked_pipo_first_round_top_defines.svh -----
// Assertion macros for the checker file of this block.
// Both macros sample on the rising clock edge and are quiet while reset is low.
`ifndef MASKED_PIPO_FIRST_ROUND_TOP_DEFINES_SVH
`define MASKED_PIPO_FIRST_ROUND_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmfr checker: property failed");

// The consequent must hold in the cycle after the antecedent.
`define PMFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmfr checker: property failed");

`endif

// ----- hdl/pmfr_pkg.sv -----
`timescale 1ns / 1ps

package pmfr_pkg;

  // One 64-bit block as eight bytes; byte i sits in bits 8i+7..8i.
  typedef logic [7:0][7:0] block_t;

  // The two seed mask bytes and the eight derived ones.
  typedef logic [9:0][7:0] masks_t;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHITENING_KEY   = 8'd0,
    REG_FIRST_ROUND_KEY = 8'd1
  } cfg_reg_e;

  // Round constant of the first round, added to byte 0.
  localparam logic [7:0] ROUND_CONST_1 = 8'h01;

  // Bytes of the plaintext that take mask m1; the rest take m0.
  localparam logic [7:0] PT_LANES_M1 = 8'b1001_0001;

  // Byte of the whitening key that takes mask m1; the rest take m2.
  localparam int unsigned WK_LANE_M1 = 3;

  // Left-rotation amounts of the bit-rotation layer, by byte.
  localparam logic [2:0] RLAYER_ROT [8] = '{3'd0, 3'd7, 3'd4, 3'd3, 3'd6, 3'd5, 3'd1, 3'd2};

  function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] n);
    logic [15:0] t;
    t = {v, v} << n;
    return t[15:8];
  endfunction

  // Secure AND gadget on shares (a, ma) and (b, mb) with fresh mask r.
  function automatic logic [7:0] sec_and(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] ma, input logic [7:0] mb,
                                         input logic [7:0] r);
    return (a & b) ^ r ^ (a & mb) ^ (ma & b) ^ (ma & mb);
  endfunction

  // Secure OR gadget on the same share layout.
  function automatic logic [7:0] sec_or(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] ma, input logic [7:0] mb,
                                        input logic [7:0] r);
    logic [7:0] u;
    logic [7:0] v;
    u = (r ^ mb) ^ (b | ma);
    v = (b & a) ^ (a | mb);
    return u ^ v;
  endfunction

endpackage

// ----- hdl/pmfr_mask_gen.sv -----
`timescale 1ns / 1ps

module pmfr_mask_gen import pmfr_pkg::*; (
  input  logic [7:0] mask_a_i,
  input  logic [7:0] mask_b_i,
  output masks_t     masks_o
);

  logic [7:0] m2;

  assign m2 = mask_a_i ^ mask_b_i;

  assign masks_o[0] = mask_a_i;
  assign masks_o[1] = mask_b_i;
  assign masks_o[2] = m2;
  assign masks_o[3] = rotl8(mask_b_i, 3'd7) ^ mask_b_i;
  assign masks_o[4] = rotl8(m2, 3'd4) ^ mask_b_i;
  assign masks_o[5] = rotl8(mask_a_i, 3'd3) ^ m2;
  assign masks_o[6] = rotl8(mask_b_i, 3'd6) ^ mask_a_i;
  assign masks_o[7] = rotl8(mask_b_i, 3'd5) ^ mask_b_i;
  assign masks_o[8] = rotl8(m2, 3'd1) ^ mask_b_i;
  assign masks_o[9] = rotl8(mask_b_i, 3'd2) ^ mask_a_i;

endmodule

// ----- hdl/pmfr_sbox.sv -----
`timescale 1ns / 1ps

module pmfr_sbox import pmfr_pkg::*; (
  input  block_t     state_i,
  input  logic [7:0] m0_i,
  input  logic [7:0] m1_i,
  input  logic [7:0] m2_i,
  output block_t     state_o
);

  block_t     s;
  logic [7:0] c;
  logic [7:0] t0;
  logic [7:0] t1;
  logic [7:0] t2;

  assign c = m0_i | m1_i;

  // Bitsliced masked S-layer: each byte lane holds one bit of all eight S-boxes.
  always_comb begin
    s = state_i;

    s[5] = s[5] ^ sec_and(s[7], s[6], m0_i, m1_i, m2_i);
    s[4] = s[4] ^ sec_and(s[3], s[5], m2_i, m0_i, m1_i);
    s[7] = s[7] ^ s[4];
    s[6] = s[6] ^ s[3];
    s[3] = s[3] ^ sec_or(s[5], s[4], m0_i, m2_i, c);
    s[5] = s[5] ^ s[7];
    s[4] = s[4] ^ sec_and(s[5], s[6], m2_i, m0_i, m1_i);
    s[2] = s[2] ^ sec_and(s[1], s[0], m1_i, m0_i, m2_i);
    s[0] = s[0] ^ sec_or(s[1], s[2], m1_i, m0_i, c);
    s[1] = s[1] ^ sec_or(s[2], s[0], m0_i, m2_i, c);
    s[2] = ~s[2];

    s[7] = s[7] ^ s[1];
    s[3] = s[3] ^ s[2];
    s[4] = s[4] ^ s[0];
    t0 = s[7];
    t1 = s[3];
    t2 = s[4];

    s[6] = s[6] ^ sec_and(s[5], t0, m2_i, m0_i, m1_i);
    t0 = t0 ^ s[6];
    s[6] = s[6] ^ sec_or(t2, t1, m1_i, m2_i, c);
    t1 = t1 ^ (s[5] ^ m0_i);
    s[5] = s[5] ^ sec_or(s[6], t2, m0_i, m1_i, c);
    t2 = t2 ^ sec_and(t1, t0, m0_i, m1_i, m2_i);

    // Output wiring of the lanes.
    s[2] = s[2] ^ t0;
    t0 = s[1] ^ t2;
    s[1] = s[0] ^ t1;
    s[0] = s[7] ^ m1_i;
    s[7] = t0;
    t1 = s[3];
    s[3] = s[6];
    s[6] = t1;
    t2 = s[4];
    s[4] = s[5];
    s[5] = t2;
  end

  assign state_o = s;

endmodule

// ----- hdl/pmfr_round.sv -----
`timescale 1ns / 1ps

module pmfr_round import pmfr_pkg::*; (
  input  block_t     plaintext_i,
  input  logic [7:0] mask_a_i,
  input  logic [7:0] mask_b_i,
  input  block_t     whitening_key_i,
  input  block_t     round_key_i,
  output block_t     masked_plaintext_o,
  output block_t     round_one_state_o
);

  masks_t m;
  block_t masked_pt;
  block_t whitened;
  block_t sbox_out;
  block_t rot_out;

  pmfr_mask_gen u_mask_gen (
    .mask_a_i (mask_a_i),
    .mask_b_i (mask_b_i),
    .masks_o  (m)
  );

  // Input masking and masked whitening key.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked_pt[i] = plaintext_i[i] ^ (PT_LANES_M1[i] ? m[1] : m[0]);
      whitened[i]  = masked_pt[i] ^ whitening_key_i[i] ^ ((i == WK_LANE_M1) ? m[1] : m[2]);
    end
  end

  pmfr_sbox u_sbox (
    .state_i (whitened),
    .m0_i    (m[0]),
    .m1_i    (m[1]),
    .m2_i    (m[2]),
    .state_o (sbox_out)
  );

  // Bit-rotation layer and masked round key.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rot_out[i] = rotl8(sbox_out[i], RLAYER_ROT[i]);
    end
    round_one_state_o[0] = rot_out[0] ^ round_key_i[0] ^ m[1] ^ ROUND_CONST_1;
    for (int i = 1; i < 8; i++) begin
      round_one_state_o[i] = rot_out[i] ^ round_key_i[i] ^ m[i+2];
    end
  end

  assign masked_plaintext_o = masked_pt;

endmodule

// ----- hdl/masked_pipo_first_round_top.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Payload
// in      | request   | in_valid_i, in_stall_o | plaintext_i, mask_a_i, mask_b_i
// out     | result    | out_valid_o, out_stall_i | masked_plaintext_o, round_one_state_o
// cfg     | write     | cfg_valid_i, cfg_ready_o | cfg_index_i, cfg_data_i
//
// A request is accepted every cycle while in_stall_o is low; its result passes through
// the input register, one combinational round and the result register before it is
// offered on out_valid_o.
// Reset clears both key registers to zero and empties both pipeline stages.
// A stall on the result side holds the result register; an empty input register
// still takes one more request, and in_stall_o is raised while that register is full.
// Configuration writes are always ready and are registered into the key registers.

module masked_pipo_first_round_top import pmfr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [63:0]           plaintext_i,
  input  logic [7:0]            mask_a_i,
  input  logic [7:0]            mask_b_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [63:0]           masked_plaintext_o,
  output logic [63:0]           round_one_state_o,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Key registers.
  logic [63:0] wkey_q;
  logic [63:0] rkey_q;

  // Input stage.
  logic        in_vld_q;
  logic [63:0] pt_q;
  logic [7:0]  ma_q;
  logic [7:0]  mb_q;

  // Result stage.
  logic        out_vld_q;
  logic [63:0] mp_q;
  logic [63:0] st_q;
  logic [63:0] mp_d;
  logic [63:0] st_d;

  logic out_free;
  logic in_take;
  logic adv;

  // The configuration port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wkey_q <= '0;
      rkey_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WHITENING_KEY:   wkey_q <= cfg_data_i;
        REG_FIRST_ROUND_KEY: rkey_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The result register can load when it is empty or being drained this cycle.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pt_q <= plaintext_i;
      ma_q <= mask_a_i;
      mb_q <= mask_b_i;
    end
  end

  pmfr_round u_round (
    .plaintext_i        (pt_q),
    .mask_a_i           (ma_q),
    .mask_b_i           (mb_q),
    .whitening_key_i    (wkey_q),
    .round_key_i        (rkey_q),
    .masked_plaintext_o (mp_d),
    .round_one_state_o  (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mp_q <= mp_d;
      st_q <= st_d;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign masked_plaintext_o = mp_q;
  assign round_one_state_o  = st_q;

endmodule

// ----- hdl/pmfr_checker.sv -----
`timescale 1ns / 1ps
`include "masked_pipo_first_round_top_defines.svh"

module pmfr_checker import pmfr_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [63:0]           masked_plaintext_o,
  input logic [63:0]           round_one_state_o
);

  // A stalled result stays offered.
  `PMFR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result keeps its value.
  `PMFR_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i,
                    $stable(round_one_state_o) && $stable(masked_plaintext_o))

  // Requests are only held off while a finished result is itself stalled.
  `PMFR_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // An accepted request that finds the result side free shows up as a valid result.
  `PMFR_ASSERT_NEXT(a_latency, clk_i, rst_ni, (in_valid_i && !in_stall_o) ##1 !out_stall_i,
                    out_valid_o)

endmodule

bind masked_pipo_first_round_top pmfr_checker u_pmfr_checker (.*);
